// ===== sv/bsfd_pkg.sv =====
// Shared constants, codes and control types of the bowed string synthesizer.
package bsfd_pkg;

  localparam int NODES       = 40;
  localparam int OUT_TAP     = 10;
  localparam int PLUCK_POS   = 30;
  localparam int TABLE_DEPTH = 256;

  localparam int DATA_W    = 32;
  localparam int RHO_W     = 28;
  localparam int COUNT_W   = 16;
  localparam int ELAPSED_W = 18;
  localparam int OUT_W     = 20;
  localparam int FRAC_W    = 28;
  localparam int DAMP_SH   = 13;
  localparam int OUT_SH    = 12;
  localparam int CFG_IDX_W = 2;

  localparam int NODE_AW  = $clog2(NODES);
  localparam int CNT_W    = $clog2(NODES + 1);
  localparam int TBL_AW   = $clog2(TABLE_DEPTH);
  localparam int TAP_NODE = OUT_TAP % NODES;
  localparam int PROD_W   = 2 * DATA_W + 1;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_NOTE   = 2'd1,
    CMD_TBL_WR = 2'd2
  } command_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RISE_SAMPLES = 2'd0,
    REG_FALL_SAMPLES = 2'd1,
    REG_RISE_STEP    = 2'd2,
    REG_FALL_STEP    = 2'd3
  } reg_index_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TRD,
    S_DMUL,
    S_DRV,
    S_WALK,
    S_DRAIN,
    S_OUT
  } state_t;

  typedef struct packed {
    logic             env_step;
    logic             note_load;
    logic             tbl_wr;
    logic             tbl_rd;
    logic             drv_mul;
    logic             drv_load;
    logic             rd_en;
    logic [CNT_W-1:0] rd_idx;
    logic             out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic busy;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== sv/bsfd_if.sv =====
// Handshake channel interfaces for the input, result and configuration beats.
interface bsfd_in_if import bsfd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               command;
  logic [RHO_W-1:0]         tension_ratio;
  logic [DATA_W-1:0]        phase_step;
  logic [TBL_AW-1:0]        table_index;
  logic signed [DATA_W-1:0] table_value;

  modport source(output valid, command, tension_ratio, phase_step, table_index,
                 table_value, input ready);
  modport sink(input valid, command, tension_ratio, phase_step, table_index,
               table_value, output ready);
endinterface

interface bsfd_out_if import bsfd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] string_sample;
  logic signed [OUT_W-1:0] drive_sample;

  modport source(output valid, string_sample, drive_sample, input ready);
  modport sink(input valid, string_sample, drive_sample, output ready);
endinterface

interface bsfd_cfg_if import bsfd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== sv/bsfd_ctrl.sv =====
// Sequencing controller: accepts beats and steps the datapath through one tick.
module bsfd_ctrl import bsfd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_command,
  output logic       in_ready,
  input  dp_stat_t   st,
  output ctrl_cmd_t  cmd
);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && in_command == CMD_TICK) begin
          state_nxt = S_TRD;
        end
      end
      S_TRD:  state_nxt = S_DMUL;
      S_DMUL: state_nxt = S_DRV;
      S_DRV: begin
        state_nxt = S_WALK;
        cnt_nxt   = '0;
      end
      S_WALK: begin
        if (cnt_r == CNT_W'(NODES)) begin
          state_nxt = S_DRAIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DRAIN: begin
        if (!st.busy) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (st.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.rd_idx = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.env_step  = accept && (in_command == CMD_TICK);
        cmd.note_load = accept && (in_command == CMD_NOTE);
        cmd.tbl_wr    = accept && (in_command == CMD_TBL_WR);
      end
      S_TRD:   cmd.tbl_rd   = 1'b1;
      S_DMUL:  cmd.drv_mul  = 1'b1;
      S_DRV:   cmd.drv_load = 1'b1;
      S_WALK:  cmd.rd_en    = 1'b1;
      S_DRAIN: cmd.rd_en    = 1'b0;
      S_OUT:   cmd.out_load = st.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== sv/bsfd_dp.sv =====
// Datapath: envelope, drive table, shared multiplier and the node update pipeline.
module bsfd_dp import bsfd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ctrl_cmd_t                cmd,
  output dp_stat_t                 st,
  input  logic [RHO_W-1:0]         in_tension_ratio,
  input  logic [DATA_W-1:0]        in_phase_step,
  input  logic [TBL_AW-1:0]        in_table_index,
  input  logic signed [DATA_W-1:0] in_table_value,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DATA_W-1:0]        cfg_data,
  input  logic                     out_ready,
  output logic                     out_valid,
  output logic signed [OUT_W-1:0]  out_string_sample,
  output logic signed [OUT_W-1:0]  out_drive_sample
);

  logic [COUNT_W-1:0]       rise_samples_r, fall_samples_r;
  logic [RHO_W-1:0]         rise_step_r, fall_step_r;
  logic [RHO_W-1:0]         tension_r;
  logic [DATA_W-1:0]        note_step_r, phase_r;
  logic [DATA_W-1:0]        amp_r;
  logic [ELAPSED_W-1:0]     elapsed_r;
  logic                     act_r;
  logic [COUNT_W:0]         env_len;
  logic                     env_run;

  logic signed [DATA_W-1:0] tbl_mem [TABLE_DEPTH];
  logic signed [DATA_W-1:0] tbl_q_r;
  logic signed [DATA_W-1:0] drive_r;

  logic [2*DATA_W-1:0]      node_mem [NODES];
  logic [2*DATA_W-1:0]      node_q_r;
  logic [NODES-1:0]         node_vld_r;
  logic                     rd_vld_r;
  logic                     rd_inr;
  logic [NODE_AW-1:0]       rd_addr;

  logic                     s1_vld_r, s2_vld_r, s3_vld_r;
  logic [CNT_W-1:0]         s1_idx_r, s2_idx_r;
  logic [CNT_W-1:0]         s2_center;
  logic [NODE_AW-1:0]       s3_n_r;
  logic signed [DATA_W-1:0] cur_in, prev_in;
  logic signed [DATA_W-1:0] wc0_r, wc1_r, wc2_r, wp1_r, wp2_r;
  logic signed [DATA_W-1:0] c3_r, p3_r;
  logic signed [DATA_W-1:0] lap;

  logic signed [DATA_W:0]   mul_a;
  logic signed [DATA_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [DATA_W-1:0] prod_fix;

  logic signed [DATA_W-1:0] pd, xs, ys, yv;
  logic                     inner;
  logic signed [DATA_W-1:0] tap_r;
  logic signed [DATA_W-1:0] tap_sh, drv_sh;
  logic                     out_valid_r;
  logic signed [OUT_W-1:0]  string_r, drive_out_r;

  function automatic logic signed [DATA_W-1:0] drive_share(
    input logic [NODE_AW-1:0]     n,
    input logic signed [DATA_W-1:0] d
  );
    int span;
    span = int'(n) - PLUCK_POS;
    if (span == 0) begin
      return d;
    end else if (span == 1 || span == -1) begin
      return d >>> 1;
    end else if (span == 2 || span == -2) begin
      return d >>> 2;
    end else if (span == 3 || span == -3) begin
      return d >>> 3;
    end
    return '0;
  endfunction

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rise_samples_r <= COUNT_W'(1000);
      fall_samples_r <= COUNT_W'(1000);
      rise_step_r    <= '0;
      fall_step_r    <= '0;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_RISE_SAMPLES: rise_samples_r <= cfg_data[COUNT_W-1:0];
        REG_FALL_SAMPLES: fall_samples_r <= cfg_data[COUNT_W-1:0];
        REG_RISE_STEP:    rise_step_r    <= cfg_data[RHO_W-1:0];
        REG_FALL_STEP:    fall_step_r    <= cfg_data[RHO_W-1:0];
      endcase
    end
  end

  assign env_len = {1'b0, rise_samples_r} + {1'b0, fall_samples_r};
  assign env_run = elapsed_r < ELAPSED_W'(env_len);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tension_r   <= '0;
      note_step_r <= '0;
      phase_r     <= '0;
      amp_r       <= '0;
      elapsed_r   <= '0;
      act_r       <= 1'b0;
    end else if (cmd.note_load) begin
      tension_r   <= in_tension_ratio;
      note_step_r <= in_phase_step;
      amp_r       <= '0;
      elapsed_r   <= '0;
    end else if (cmd.env_step) begin
      act_r <= env_run;
      if (env_run) begin
        if (elapsed_r <= ELAPSED_W'(rise_samples_r)) begin
          amp_r <= amp_r + DATA_W'(rise_step_r);
        end else begin
          amp_r <= amp_r - DATA_W'(fall_step_r);
        end
        phase_r <= phase_r + note_step_r;
      end
      if (elapsed_r != {ELAPSED_W{1'b1}}) begin
        elapsed_r <= elapsed_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tbl_wr) begin
      tbl_mem[in_table_index] <= in_table_value;
    end
    if (cmd.tbl_rd) begin
      tbl_q_r <= tbl_mem[phase_r[DATA_W-1 -: TBL_AW]];
    end
  end

  // One multiplier serves the drive scaling and every node's tension term.
  assign lap = wc0_r + wc2_r - (wc1_r <<< 1);

  always_comb begin
    if (cmd.drv_mul) begin
      mul_a = {amp_r[DATA_W-1], amp_r};
      mul_b = tbl_q_r;
    end else begin
      mul_a = $signed({{(DATA_W + 1 - RHO_W){1'b0}}, tension_r});
      mul_b = lap;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  assign prod_fix = prod_r[FRAC_W + DATA_W - 1:FRAC_W];

  always_ff @(posedge clk) begin
    if (cmd.drv_load) begin
      drive_r <= act_r ? prod_fix : '0;
    end
  end

  // Node memory read.
  assign rd_inr  = cmd.rd_idx < CNT_W'(NODES);
  assign rd_addr = cmd.rd_idx[NODE_AW-1:0];

  always_ff @(posedge clk) begin
    if (s3_vld_r) begin
      node_mem[s3_n_r] <= {yv, c3_r};
    end
    if (cmd.rd_en && rd_inr) begin
      node_q_r <= node_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_vld_r <= '0;
      rd_vld_r   <= 1'b0;
      s1_vld_r   <= 1'b0;
      s2_vld_r   <= 1'b0;
      s3_vld_r   <= 1'b0;
    end else begin
      if (s3_vld_r) begin
        node_vld_r[s3_n_r] <= 1'b1;
      end
      rd_vld_r <= cmd.rd_en && rd_inr && node_vld_r[rd_addr];
      s1_vld_r <= cmd.rd_en;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r && (s2_idx_r != '0);
    end
  end

  assign cur_in  = rd_vld_r ? node_q_r[2*DATA_W-1:DATA_W] : '0;
  assign prev_in = rd_vld_r ? node_q_r[DATA_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      s1_idx_r <= cmd.rd_idx;
    end
    if (s1_vld_r) begin
      wc0_r    <= wc1_r;
      wc1_r    <= wc2_r;
      wc2_r    <= cur_in;
      wp1_r    <= wp2_r;
      wp2_r    <= prev_in;
      s2_idx_r <= s1_idx_r;
    end
  end

  assign s2_center = s2_idx_r - 1'b1;

  always_ff @(posedge clk) begin
    if (s2_vld_r) begin
      s3_n_r <= s2_center[NODE_AW-1:0];
      c3_r   <= wc1_r;
      p3_r   <= wp1_r;
    end
  end

  assign pd    = p3_r - (p3_r >>> DAMP_SH);
  assign xs    = prod_fix + (c3_r <<< 1) - pd;
  assign ys    = xs - (xs >>> DAMP_SH);
  assign inner = (s3_n_r >= NODE_AW'(1)) && (s3_n_r <= NODE_AW'(NODES - 3));
  assign yv    = inner ? ys + drive_share(s3_n_r, drive_r) : '0;

  always_ff @(posedge clk) begin
    if (s3_vld_r && s3_n_r == NODE_AW'(TAP_NODE)) begin
      tap_r <= yv;
    end
  end

  // Result register.
  assign tap_sh = tap_r >>> OUT_SH;
  assign drv_sh = drive_r >>> OUT_SH;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      string_r    <= tap_sh[OUT_W-1:0];
      drive_out_r <= drv_sh[OUT_W-1:0];
    end
  end

  assign st.busy           = s1_vld_r || s2_vld_r || s3_vld_r;
  assign st.out_free       = !out_valid_r || out_ready;
  assign out_valid         = out_valid_r;
  assign out_string_sample = string_r;
  assign out_drive_sample  = drive_out_r;

endmodule

// ===== sv/bowed_string_fd_synth.sv =====
// Top level of the driven finite-difference string synthesizer.
// A sample tick runs from its accepting edge until the next beat can be taken:
// envelope and drive-table work in the table-read, multiply and drive-load
// states, a walk over read indices 0 to NODES in which the nodes pass
// one per cycle through the node memory (read and written in the same cycle)
// and the one shared multiplier, a drain of the three-stage node pipeline,
// the result load and the return to idle, where the next beat is taken.
// Note start, table write and unknown commands leave the controller idle and give no
// result. A finished result waits in the output register while the next beat
// is taken; a tick that finishes before it is taken holds until it leaves.
module bowed_string_fd_synth import bsfd_pkg::*; (
  input logic         clk,
  input logic         rst_n,
  bsfd_cfg_if.sink    cfg_bus,
  bsfd_in_if.sink     in_bus,
  bsfd_out_if.source  out_bus
);

  ctrl_cmd_t cmd;
  dp_stat_t  st;

  assign cfg_bus.ready = 1'b1;

  bsfd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_bus.valid),
    .in_command (in_bus.command),
    .in_ready   (in_bus.ready),
    .st         (st),
    .cmd        (cmd)
  );

  bsfd_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .st                (st),
    .in_tension_ratio  (in_bus.tension_ratio),
    .in_phase_step     (in_bus.phase_step),
    .in_table_index    (in_bus.table_index),
    .in_table_value    (in_bus.table_value),
    .cfg_we            (cfg_bus.valid),
    .cfg_index         (cfg_bus.index),
    .cfg_data          (cfg_bus.data),
    .out_ready         (out_bus.ready),
    .out_valid         (out_bus.valid),
    .out_string_sample (out_bus.string_sample),
    .out_drive_sample  (out_bus.drive_sample)
  );

  // The input side only opens when no node is still in flight.
  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    in_bus.ready |-> !st.busy)
    else $error("input ready while the node pipeline is busy");

  a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |-> (cmd.rd_idx <= CNT_W'(NODES)))
    else $error("node walk index beyond the last node");

  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_bus.valid || out_bus.ready))
    else $error("result loaded over a beat not yet taken");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_bus.valid) |-> $past(cmd.out_load))
    else $error("result valid without a load");

endmodule

// ===== verif/tb_bowed_string_fd_synth.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the bowed string synthesizer against a built-in predictor.
module tb_bowed_string_fd_synth;
  import bsfd_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned ELAPSED_TOP = (1 << ELAPSED_W) - 1;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [RHO_W-1:0]  tension;
    logic [DATA_W-1:0] step;
    logic [TBL_AW-1:0] idx;
    logic [DATA_W-1:0] value;
  } beat_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] string_sample;
    logic signed [OUT_W-1:0] drive_sample;
  } sample_t;

  logic clk;
  logic rst_n;

  bsfd_cfg_if cfg_bus();
  bsfd_in_if  in_bus();
  bsfd_out_if out_bus();

  bowed_string_fd_synth u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_bus (cfg_bus),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  beat_t       pending_beats[$];
  sample_t     expected_samples[$];
  beat_t       cur_beat;
  int          beats_open;
  int          mismatches;
  int          idle_pct;
  int          in_gap;
  int          out_stall;
  bit          in_taken;

  int unsigned       cfg_rise_len;
  int unsigned       cfg_fall_len;
  logic [RHO_W-1:0]  cfg_rise_step;
  logic [RHO_W-1:0]  cfg_fall_step;

  logic [DATA_W-1:0] node_now [NODES];
  logic [DATA_W-1:0] node_old [NODES];
  logic [DATA_W-1:0] drive_tbl [TABLE_DEPTH];
  logic [DATA_W-1:0] phase_acc;
  logic [DATA_W-1:0] phase_inc;
  logic [DATA_W-1:0] amplitude;
  logic [RHO_W-1:0]  rho;
  int unsigned       elapsed;

  logic [DATA_W-1:0] g_phase;
  logic [DATA_W-1:0] g_step;
  int unsigned       g_elapsed;
  bit                g_written [TABLE_DEPTH];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [DATA_W-1:0] asr(logic [DATA_W-1:0] v, int n);
    return $signed(v) >>> n;
  endfunction

  function automatic logic [DATA_W-1:0] fix_mul(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
    logic signed [2*DATA_W-1:0] prod;
    prod = $signed({{DATA_W{a[DATA_W-1]}}, a}) * $signed({{DATA_W{b[DATA_W-1]}}, b});
    return prod[FRAC_W+DATA_W-1:FRAC_W];
  endfunction

  task automatic take_beat(input beat_t b);
    logic [DATA_W-1:0] fresh [NODES];
    logic [DATA_W-1:0] c;
    logic [DATA_W-1:0] p;
    logic [DATA_W-1:0] t;
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] drive;
    sample_t s;
    case (b.cmd)
      CMD_NOTE: begin
        rho = b.tension;
        phase_inc = b.step;
        elapsed = 0;
        amplitude = '0;
      end
      CMD_TBL_WR: drive_tbl[b.idx] = b.value;
      CMD_TICK: begin
        for (int i = 0; i < NODES; i++) fresh[i] = '0;
        for (int i = 1; i <= NODES - 3; i++) begin
          c = node_now[i];
          p = node_old[i];
          t = node_now[i-1] + node_now[i+1] - (c << 1);
          x = fix_mul({{(DATA_W-RHO_W){1'b0}}, rho}, t) + (c << 1) - (p - asr(p, DAMP_SH));
          fresh[i] = x - asr(x, DAMP_SH);
        end
        drive = '0;
        if (elapsed < cfg_rise_len + cfg_fall_len) begin
          if (elapsed <= cfg_rise_len) amplitude += {{(DATA_W-RHO_W){1'b0}}, cfg_rise_step};
          else amplitude -= {{(DATA_W-RHO_W){1'b0}}, cfg_fall_step};
          phase_acc += phase_inc;
          drive = fix_mul(amplitude, drive_tbl[phase_acc[DATA_W-1 -: TBL_AW]]);
        end
        if (elapsed < ELAPSED_TOP) elapsed++;
        for (int k = -3; k <= 3; k++) begin
          if (PLUCK_POS + k >= 1 && PLUCK_POS + k <= NODES - 3)
            fresh[PLUCK_POS+k] += asr(drive, (k < 0) ? -k : k);
        end
        node_old = node_now;
        node_now = fresh;
        s.string_sample = OUT_W'(asr(fresh[TAP_NODE], OUT_SH));
        s.drive_sample = OUT_W'(asr(drive, OUT_SH));
        expected_samples.push_back(s);
      end
      default: ;
    endcase
  endtask

  task automatic note_mismatch(input string what, input logic signed [OUT_W-1:0] want,
                               input logic signed [OUT_W-1:0] got);
    if (mismatches < 10) $display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
    mismatches++;
  endtask

  // Ticks that would read a never-written table word get a table write queued ahead of them.
  task automatic queue_beat(input beat_t b);
    beat_t fill;
    case (b.cmd)
      CMD_NOTE: begin
        g_step = b.step;
        g_elapsed = 0;
      end
      CMD_TBL_WR: g_written[b.idx] = 1'b1;
      CMD_TICK: begin
        if (g_elapsed < cfg_rise_len + cfg_fall_len) begin
          g_phase += g_step;
          if (!g_written[g_phase[DATA_W-1 -: TBL_AW]]) begin
            fill = b;
            fill.cmd = CMD_TBL_WR;
            fill.idx = g_phase[DATA_W-1 -: TBL_AW];
            fill.value = $urandom;
            g_written[fill.idx] = 1'b1;
            pending_beats.push_back(fill);
            beats_open++;
          end
        end
        if (g_elapsed < ELAPSED_TOP) g_elapsed++;
      end
      default: ;
    endcase
    pending_beats.push_back(b);
    beats_open++;
  endtask

  function automatic beat_t random_beat();
    beat_t b;
    int roll;
    roll = $urandom_range(0, 99);
    b.tension = RHO_W'($urandom);
    b.step = $urandom;
    b.idx = TBL_AW'($urandom);
    b.value = $urandom;
    if (roll < 70) b.cmd = CMD_TICK;
    else if (roll < 78) b.cmd = CMD_NOTE;
    else if (roll < 95) b.cmd = CMD_TBL_WR;
    else b.cmd = CMD_UNUSED;
    return b;
  endfunction

  function automatic beat_t make_beat(logic [1:0] cmd, logic [RHO_W-1:0] tension,
                                      logic [DATA_W-1:0] step, logic [TBL_AW-1:0] idx,
                                      logic [DATA_W-1:0] value);
    beat_t b;
    b.cmd = cmd;
    b.tension = tension;
    b.step = step;
    b.idx = idx;
    b.value = value;
    return b;
  endfunction

  // Called at a falling edge; returns at a falling edge with valid still high.
  task automatic write_reg(input reg_index_t r, input logic [DATA_W-1:0] val);
    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] word;
    mask = (r == REG_RISE_SAMPLES || r == REG_FALL_SAMPLES) ? 32'h0000_FFFF : 32'h0FFF_FFFF;
    word = (val & mask) | ($urandom & ~mask);
    cfg_bus.index <= r;
    cfg_bus.data <= word;
    cfg_bus.valid <= 1'b1;
    do @(posedge clk); while (!cfg_bus.ready);
    case (r)
      REG_RISE_SAMPLES: cfg_rise_len = 32'(word[COUNT_W-1:0]);
      REG_FALL_SAMPLES: cfg_fall_len = 32'(word[COUNT_W-1:0]);
      REG_RISE_STEP:    cfg_rise_step = word[RHO_W-1:0];
      REG_FALL_STEP:    cfg_fall_step = word[RHO_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_envelope(input int unsigned rise_len, input int unsigned fall_len,
                              input logic [RHO_W-1:0] rise_step,
                              input logic [RHO_W-1:0] fall_step);
    write_reg(REG_RISE_SAMPLES, rise_len);
    write_reg(REG_FALL_SAMPLES, fall_len);
    write_reg(REG_RISE_STEP, {4'b0, rise_step});
    write_reg(REG_FALL_STEP, {4'b0, fall_step});
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic settle();
    while (beats_open != 0 || expected_samples.size() != 0) @(negedge clk);
    repeat (NODES + 24) @(negedge clk);
  endtask

  always @(posedge clk) begin
    in_taken = 1'b0;
    if (rst_n && in_bus.valid && in_bus.ready) begin
      in_taken = 1'b1;
      take_beat(cur_beat);
      beats_open--;
    end
  end

  always @(negedge clk) begin
    if (in_bus.valid && !in_taken) begin
    end else if (in_gap > 0) begin
      in_gap--;
      in_bus.valid <= 1'b0;
    end else if (pending_beats.size() != 0) begin
      cur_beat = pending_beats.pop_front();
      in_bus.command <= cur_beat.cmd;
      in_bus.tension_ratio <= cur_beat.tension;
      in_bus.phase_step <= cur_beat.step;
      in_bus.table_index <= cur_beat.idx;
      in_bus.table_value <= cur_beat.value;
      in_bus.valid <= 1'b1;
      if ($urandom_range(0, 99) < idle_pct) in_gap = $urandom_range(1, 8);
    end else begin
      in_bus.valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_stall--;
      out_bus.ready <= 1'b0;
    end else if ($urandom_range(0, 99) < idle_pct) begin
      out_stall = $urandom_range(0, 7);
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    sample_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (expected_samples.size() == 0) begin
        note_mismatch("unexpected string sample", 'x, out_bus.string_sample);
      end else begin
        want = expected_samples.pop_front();
        if (out_bus.string_sample !== want.string_sample)
          note_mismatch("string_sample", want.string_sample, out_bus.string_sample);
        if (out_bus.drive_sample !== want.drive_sample)
          note_mismatch("drive_sample", want.drive_sample, out_bus.drive_sample);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("tb_bowed_string_fd_synth NOT OK");
    $finish;
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = REG_RISE_SAMPLES;
    cfg_bus.data = '0;
    in_bus.valid = 1'b0;
    in_bus.command = CMD_TICK;
    in_bus.tension_ratio = '0;
    in_bus.phase_step = '0;
    in_bus.table_index = '0;
    in_bus.table_value = '0;
    out_bus.ready = 1'b0;
    in_taken = 1'b0;
    beats_open = 0;
    mismatches = 0;
    in_gap = 0;
    out_stall = 0;
    idle_pct = 20;
    cfg_rise_len = 1000;
    cfg_fall_len = 1000;
    cfg_rise_step = '0;
    cfg_fall_step = '0;
    for (int i = 0; i < NODES; i++) begin
      node_now[i] = '0;
      node_old[i] = '0;
    end
    for (int i = 0; i < TABLE_DEPTH; i++) g_written[i] = 1'b0;
    phase_acc = '0;
    phase_inc = '0;
    amplitude = '0;
    rho = '0;
    elapsed = 0;
    g_phase = '0;
    g_step = '0;
    g_elapsed = 0;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    settle();

    set_envelope(3, 4, 28'hFFF_FFFF, 28'h000_0001);
    queue_beat(make_beat(CMD_TBL_WR, '0, '0, 8'd0, 32'h7FFF_FFFF));
    queue_beat(make_beat(CMD_TBL_WR, '1, '1, 8'd255, 32'h8000_0000));
    queue_beat(make_beat(CMD_TBL_WR, '0, '0, 8'd128, 32'hFFFF_FFFF));
    queue_beat(make_beat(CMD_TBL_WR, '0, '0, 8'd1, 32'h0000_0000));
    queue_beat(make_beat(CMD_NOTE, 28'hFFF_FFFF, 32'hFF00_0000, '0, '0));
    repeat (9) queue_beat(make_beat(CMD_TICK, '0, '0, '0, '0));
    queue_beat(make_beat(CMD_UNUSED, '1, '1, '1, '1));
    queue_beat(make_beat(CMD_NOTE, '0, '0, '1, '1));
    repeat (3) queue_beat(make_beat(CMD_TICK, '1, '1, '1, '1));
    queue_beat(make_beat(CMD_NOTE, 28'h800_0000, 32'h0100_0000, '0, '0));
    repeat (5) queue_beat(make_beat(CMD_TICK, '0, '0, '0, '0));

    for (int ph = 0; ph < 5; ph++) begin
      settle();
      case (ph)
        0: set_envelope($urandom_range(1, 40), $urandom_range(1, 40),
                        RHO_W'($urandom), RHO_W'($urandom));
        1: set_envelope(0, 0, '0, '0);
        2: set_envelope(16'hFFFF, 16'hFFFF, 28'hFFF_FFFF, 28'hFFF_FFFF);
        3: set_envelope(0, $urandom_range(5, 50), RHO_W'($urandom), RHO_W'($urandom));
        default: set_envelope($urandom_range(1, 30), $urandom_range(1, 30),
                              RHO_W'($urandom), RHO_W'($urandom));
      endcase
      idle_pct = (ph == 4) ? 0 : $urandom_range(5, 35);
      repeat (200) queue_beat(random_beat());
    end

    while (beats_open != 0 || expected_samples.size() != 0) @(negedge clk);
    repeat (NODES + 24) @(negedge clk);
    if (expected_samples.size() != 0) begin
      if (mismatches < 10) $display("%0d expected samples never arrived", expected_samples.size());
      mismatches += expected_samples.size();
    end
    if (mismatches == 0) $display("tb_bowed_string_fd_synth OK");
    else $display("tb_bowed_string_fd_synth NOT OK");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/bsfd_pkg.sv
sv/bsfd_if.sv
sv/bsfd_ctrl.sv
sv/bsfd_dp.sv
sv/bowed_string_fd_synth.sv
verif/tb_bowed_string_fd_synth.sv
